[rtl/lpht_pkg.sv]
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int CAP_W         = 9;
    localparam int KEY_W         = 32;
    localparam int DATA_W        = 32;
    localparam int MAX_SLOTS_DEF = 256;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STEPS     = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef struct packed {
        t_mark              mark;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
    } t_slot;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_FOUND    = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_HOME  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

endpackage

[rtl/lpht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/linear_probing_hash_table.sv]
// Top level of the key-value table with open addressing and linear probing.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    i_req_type, i_key, i_value
//  out      output     o_out_valid / i_out_stall  o_status, o_read_value, o_entries_held
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (capacity_in_use)
//
// Insert, remove, search: accept, then 8 remainder steps in S_DIV (4 key bits per cycle through
// the shared subtract/compare unit), the home slot, S_READ and S_CHECK for each probed slot
// (registered RAM read), then the result in S_DONE; a walk visits 1 to capacity slots.
// Clear: S_CLEAR writes all MAX_SLOTS slots of the slot RAM empty, then the result.
// After reset the same sweep runs, with no result, before the first item is taken.
// A stalled result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module linear_probing_hash_table
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [CAP_W-1:0]         o_entries_held,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CAP_W-1:0]         i_cfg_data
);

    localparam int AW        = $clog2(MAX_SLOTS);
    localparam int PW        = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam int CAP_TOP   = (1 << CAP_W) - 1;
    localparam int CAP_MAX_I = (MAX_SLOTS > CAP_TOP) ? CAP_TOP : MAX_SLOTS;
    localparam logic [CAP_W-1:0] CAP_LIM   = CAP_W'(CAP_MAX_I);
    localparam logic [AW-1:0]    LAST_SLOT = AW'(MAX_SLOTS - 1);

    t_state                r_state, n_state;
    logic [1:0]            r_req, n_req;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [DATA_W-1:0]     r_value, n_value;
    logic [CAP_W-1:0]      r_cap_cfg, n_cap_cfg;
    logic [CAP_W-1:0]      r_cap, n_cap;
    logic [CAP_W-1:0]      r_rem, n_rem;
    logic [KEY_W-1:0]      r_dvd, n_dvd;
    logic                  r_neg, n_neg;
    logic [DIV_CNT_W-1:0]  r_step, n_step;
    logic [AW-1:0]         r_p, n_p;
    logic [CAP_W-1:0]      r_cnt, n_cnt;
    logic                  r_have_tomb, n_have_tomb;
    logic [AW-1:0]         r_tomb, n_tomb;
    logic [AW-1:0]         r_sweep, n_sweep;
    logic                  r_emit, n_emit;
    logic [CAP_W-1:0]      r_count, n_count;
    logic [2:0]            r_res_status, n_res_status;
    logic [DATA_W-1:0]     r_res_rd, n_res_rd;
    logic                  r_out_valid, n_out_valid;
    logic [2:0]            r_out_status, n_out_status;
    logic [DATA_W-1:0]     r_out_rd, n_out_rd;
    logic [CAP_W-1:0]      r_out_held, n_out_held;

    logic [CAP_W-1:0]      cap_clamped;
    logic [KEY_W-1:0]      key_u;
    logic [KEY_W-1:0]      key_mag;
    logic [CAP_W-1:0]      div_rem;
    logic [CAP_W-1:0]      home_slot;
    logic [AW-1:0]         p_next;
    logic                  walk_last;
    logic                  slot_used;
    logic                  slot_tomb;
    logic                  slot_hit;
    t_slot                 rd_slot;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_slot                 ram_wdata;
    logic [$bits(t_slot)-1:0] ram_rdata;

    lpht_ram #(
        .W (($bits(t_slot))),
        .D (MAX_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_p),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read_value   = r_out_rd;
    assign o_entries_held = r_out_held;

    assign cap_clamped = (r_cap_cfg == '0) ? CAP_W'(1) :
                         ((r_cap_cfg > CAP_LIM) ? CAP_LIM : r_cap_cfg);
    assign key_u   = i_key;
    assign key_mag = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;

    always_comb begin
        logic [CAP_W:0]   t;
        logic [CAP_W-1:0] rem;
        rem = r_rem;
        for (int j = 0; j < DIV_BITS; j++) begin
            t = {rem, r_dvd[KEY_W-1-j]};
            if (t >= {1'b0, r_cap}) begin
                t = t - {1'b0, r_cap};
            end
            rem = t[CAP_W-1:0];
        end
        div_rem = rem;
    end

    assign home_slot = (r_neg && (r_rem != '0)) ? (r_cap - r_rem) : r_rem;
    assign p_next    = ((PW'(r_p) + PW'(1)) >= PW'(r_cap)) ? '0 : (r_p + AW'(1));
    assign walk_last = ((r_cnt + CAP_W'(1)) == r_cap);

    assign rd_slot   = t_slot'(ram_rdata);
    assign slot_used = (rd_slot.mark == MARK_USED);
    assign slot_tomb = (rd_slot.mark == MARK_TOMB);
    assign slot_hit  = slot_used && (rd_slot.key == r_key);

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_key        = r_key;
        n_value      = r_value;
        n_cap_cfg    = i_cfg_valid ? i_cfg_data : r_cap_cfg;
        n_cap        = r_cap;
        n_rem        = r_rem;
        n_dvd        = r_dvd;
        n_neg        = r_neg;
        n_step       = r_step;
        n_p          = r_p;
        n_cnt        = r_cnt;
        n_have_tomb  = r_have_tomb;
        n_tomb       = r_tomb;
        n_sweep      = r_sweep;
        n_emit       = r_emit;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_rd     = r_res_rd;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_rd     = r_out_rd;
        n_out_held   = r_out_held;
        ram_we       = 1'b0;
        ram_waddr    = r_p;
        ram_wdata    = '{mark: MARK_USED, key: r_key, data: r_value};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_req_type;
                    n_key   = i_key;
                    n_value = i_value;
                    if (i_req_type == REQ_CLEAR) begin
                        n_sweep = '0;
                        n_emit  = 1'b1;
                        n_count = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_cap   = cap_clamped;
                        n_rem   = '0;
                        n_dvd   = key_mag;
                        n_neg   = key_u[KEY_W-1];
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = div_rem;
                n_dvd  = r_dvd << DIV_BITS;
                n_step = r_step + DIV_CNT_W'(1);
                if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                n_p         = AW'(home_slot);
                n_cnt       = '0;
                n_have_tomb = 1'b0;
                n_state     = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res_rd = '0;
                case (r_req)
                    REQ_INSERT: begin
                        if (slot_hit) begin
                            ram_we       = 1'b1;
                            n_res_status = ST_UPDATED;
                            n_state      = S_DONE;
                        end else if (slot_used || slot_tomb) begin
                            if (slot_tomb && !r_have_tomb) begin
                                n_have_tomb = 1'b1;
                                n_tomb      = r_p;
                            end
                            if (walk_last) begin
                                if (r_have_tomb || slot_tomb) begin
                                    ram_we       = 1'b1;
                                    ram_waddr    = r_have_tomb ? r_tomb : r_p;
                                    n_count      = r_count + CAP_W'(1);
                                    n_res_status = ST_INSERTED;
                                end else begin
                                    n_res_status = ST_FULL;
                                end
                                n_state = S_DONE;
                            end else begin
                                n_p     = p_next;
                                n_cnt   = r_cnt + CAP_W'(1);
                                n_state = S_READ;
                            end
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_have_tomb ? r_tomb : r_p;
                            n_count      = r_count + CAP_W'(1);
                            n_res_status = ST_INSERTED;
                            n_state      = S_DONE;
                        end
                    end
                    default: begin
                        if (slot_hit) begin
                            if (r_req == REQ_REMOVE) begin
                                ram_we       = 1'b1;
                                ram_wdata    = '{mark: MARK_TOMB, key: rd_slot.key,
                                                 data: rd_slot.data};
                                n_count      = r_count - CAP_W'(1);
                                n_res_status = ST_REMOVED;
                            end else begin
                                n_res_rd     = rd_slot.data;
                                n_res_status = ST_FOUND;
                            end
                            n_state = S_DONE;
                        end else if (!slot_used && !slot_tomb) begin
                            n_res_status = ST_MISSING;
                            n_state      = S_DONE;
                        end else if (walk_last) begin
                            n_res_status = ST_MISSING;
                            n_state      = S_DONE;
                        end else begin
                            n_p     = p_next;
                            n_cnt   = r_cnt + CAP_W'(1);
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rd     = r_res_rd;
                    n_out_held   = r_count;
                    n_state      = S_IDLE;
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = '{mark: MARK_EMPTY, key: '0, data: '0};
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == LAST_SLOT) begin
                    if (r_emit) begin
                        n_res_status = ST_CLEARED;
                        n_res_rd     = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_emit      <= 1'b0;
            r_count     <= '0;
            r_cap_cfg   <= CAP_W'(256);
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_cnt       <= '0;
            r_have_tomb <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_emit      <= n_emit;
            r_count     <= n_count;
            r_cap_cfg   <= n_cap_cfg;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_have_tomb <= n_have_tomb;
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_value      <= n_value;
        r_cap        <= n_cap;
        r_rem        <= n_rem;
        r_dvd        <= n_dvd;
        r_neg        <= n_neg;
        r_p          <= n_p;
        r_tomb       <= n_tomb;
        r_res_status <= n_res_status;
        r_res_rd     <= n_res_rd;
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_held   <= n_out_held;
    end

endmodule

[dv/lpht_checker.sv]
// Scoreboard for the hash table: tracks the slot contents and checks every returned item.
`timescale 1ns / 1ps
module lpht_checker
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [2:0]        i_status,
    input  logic [DATA_W-1:0] i_read_value,
    input  logic [CAP_W-1:0]  i_entries_held,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct {
        logic [2:0]        status;
        logic [DATA_W-1:0] read_value;
        logic [CAP_W-1:0]  entries_held;
    } t_answer;

    logic [KEY_W-1:0]  tbl_key  [MAX_SLOTS];
    logic [DATA_W-1:0] tbl_data [MAX_SLOTS];
    t_mark             tbl_mark [MAX_SLOTS];
    logic [CAP_W-1:0]  tbl_count;
    logic [CAP_W-1:0]  capacity;
    t_answer           answers_due[$];
    t_answer           got_answer;
    int                fail_total = 0;
    int                checked_total = 0;
    int                pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        fail_total++;
    endtask

    function automatic void fill_slot(int pos, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        tbl_key[pos]  = k;
        tbl_data[pos] = v;
        tbl_mark[pos] = MARK_USED;
        tbl_count     = tbl_count + 1'b1;
    endfunction

    function automatic t_answer apply_request(logic [1:0] req, logic [KEY_W-1:0] k,
                                              logic [DATA_W-1:0] v);
        t_answer ans;
        int      cap;
        int      pos;
        int      tomb;
        bit      have_tomb;
        bit      done;
        longint  signed_key;
        cap = int'(capacity);
        if (cap == 0) begin
            cap = 1;
        end
        if (cap > MAX_SLOTS) begin
            cap = MAX_SLOTS;
        end
        signed_key = longint'(signed'(k));
        pos = int'(signed_key % cap);
        if (pos < 0) begin
            pos += cap;
        end
        ans.status     = ST_MISSING;
        ans.read_value = '0;
        have_tomb      = 1'b0;
        tomb           = 0;
        done           = 1'b0;
        case (req)
            REQ_CLEAR: begin
                for (int j = 0; j < MAX_SLOTS; j++) begin
                    tbl_mark[j] = MARK_EMPTY;
                end
                tbl_count  = '0;
                ans.status = ST_CLEARED;
            end
            REQ_INSERT: begin
                for (int i = 0; i < cap && !done; i++) begin
                    if (tbl_mark[pos] == MARK_USED) begin
                        if (tbl_key[pos] == k) begin
                            tbl_data[pos] = v;
                            ans.status    = ST_UPDATED;
                            done          = 1'b1;
                        end
                    end else if (tbl_mark[pos] == MARK_TOMB) begin
                        if (!have_tomb) begin
                            have_tomb = 1'b1;
                            tomb      = pos;
                        end
                    end else begin
                        fill_slot(have_tomb ? tomb : pos, k, v);
                        ans.status = ST_INSERTED;
                        done       = 1'b1;
                    end
                    pos = (pos + 1 >= cap) ? 0 : pos + 1;
                end
                if (!done) begin
                    if (have_tomb) begin
                        fill_slot(tomb, k, v);
                        ans.status = ST_INSERTED;
                    end else begin
                        ans.status = ST_FULL;
                    end
                end
            end
            default: begin
                for (int i = 0; i < cap && !done; i++) begin
                    if (tbl_mark[pos] == MARK_USED) begin
                        if (tbl_key[pos] == k) begin
                            if (req == REQ_REMOVE) begin
                                tbl_mark[pos] = MARK_TOMB;
                                tbl_count     = tbl_count - 1'b1;
                                ans.status    = ST_REMOVED;
                            end else begin
                                ans.read_value = tbl_data[pos];
                                ans.status     = ST_FOUND;
                            end
                            done = 1'b1;
                        end
                    end else if (tbl_mark[pos] != MARK_TOMB) begin
                        done = 1'b1;
                    end
                    pos = (pos + 1 >= cap) ? 0 : pos + 1;
                end
            end
        endcase
        ans.entries_held = tbl_count;
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_SLOTS; j++) begin
                tbl_key[j]  = '0;
                tbl_data[j] = '0;
                tbl_mark[j] = MARK_EMPTY;
            end
            tbl_count = '0;
            capacity  = CAP_W'(MAX_SLOTS);
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                checked_total++;
                if (answers_due.size() == 0) begin
                    report_mismatch("unrequested item status", 32'(i_status), '0);
                end else begin
                    got_answer = answers_due.pop_front();
                    if (i_status !== got_answer.status) begin
                        report_mismatch("status", 32'(i_status), 32'(got_answer.status));
                    end
                    if (i_read_value !== got_answer.read_value) begin
                        report_mismatch("read_value", i_read_value, got_answer.read_value);
                    end
                    if (i_entries_held !== got_answer.entries_held) begin
                        report_mismatch("entries_held", 32'(i_entries_held),
                                        32'(got_answer.entries_held));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                answers_due.push_back(apply_request(i_req_type, i_key, i_value));
            end
        end
        pending_total = answers_due.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top for the hash table: clock, reset, request and capacity stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
    import lpht_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;
    localparam int HOLD_CYCLES = 150;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_req_type = REQ_INSERT;
    logic [KEY_W-1:0]  i_key = '0;
    logic [DATA_W-1:0] i_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_status;
    logic [DATA_W-1:0] o_read_value;
    logic [CAP_W-1:0]  o_entries_held;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CAP_W-1:0]  i_cfg_data = '0;

    int fail_count;
    int pending;
    int checked;

    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int                holds_done = 0;
    int                sent = 0;
    logic [KEY_W-1:0]  recent_keys [16];
    int                recent_wr = 0;

    int                cap_plan  [PHASES] = '{0, 1, 2, 7, 16, 37, 256, 511, 3, 100};
    bit                keep_plan [PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0};

    always #6 i_clk = ~i_clk;

    linear_probing_hash_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_read_value   (o_read_value),
        .o_entries_held (o_entries_held),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    lpht_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_read_value   (o_read_value),
        .i_entries_held (o_entries_held),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(logic [1:0] req, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= k;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
        if (req == REQ_INSERT) begin
            recent_keys[recent_wr] = k;
            recent_wr = (recent_wr + 1) % 16;
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= c;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // drain all outstanding items before touching the capacity register
    task automatic settle;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int cap);
        int sel;
        int off;
        int cluster;
        sel = $urandom_range(0, 99);
        off = $urandom_range(0, 3);
        if (sel < 55) begin
            cluster = cap * ($urandom_range(0, 16) - 8) + off;
            return KEY_W'(cluster);
        end else if (sel < 75) begin
            cluster = $urandom_range(0, 2 * cap + 2);
            return KEY_W'($urandom_range(0, 1) ? -cluster : cluster);
        end else if (sel < 88) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF - off;
                1:       return 32'h8000_0000 + off;
                2:       return 32'hFFFF_FFFF - off;
                default: return KEY_W'(off);
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_request(int cap);
        int               sel;
        logic [1:0]       req;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            req = REQ_INSERT;
        end else if (sel < 67) begin
            req = REQ_REMOVE;
        end else if (sel < 96) begin
            req = REQ_SEARCH;
        end else begin
            req = REQ_CLEAR;
        end
        if (req != REQ_INSERT && $urandom_range(0, 1) == 1) begin
            k = recent_keys[$urandom_range(0, 15)];
        end else begin
            k = pick_key(cap);
        end
        send_request(req, k, $urandom);
    endtask

    initial begin
        int eff_cap;
        foreach (recent_keys[j]) recent_keys[j] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // four-slot table: collisions, wraparound, tombstones and a full table
        write_capacity(CAP_W'(4));
        send_request(REQ_CLEAR,  32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0005);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(REQ_REMOVE, 32'h8000_0000, 32'h0000_0000);
        send_request(REQ_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0004, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h0000_0008, 32'h0000_0001);
        send_request(REQ_INSERT, 32'h0000_0002, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h0000_000C, 32'hAAAA_5555);
        send_request(REQ_REMOVE, 32'h0000_0002, 32'h0000_0000);
        send_request(REQ_INSERT, 32'h0000_0006, 32'h5555_AAAA);
        send_request(REQ_SEARCH, 32'h0000_0064, 32'h0000_0000);
        send_request(REQ_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0006, 32'h0000_0000);
        send_request(REQ_CLEAR,  32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_SEARCH, 32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_capacity(CAP_W'(cap_plan[p]));
            eff_cap = cap_plan[p];
            if (eff_cap < 1) begin
                eff_cap = 1;
            end
            if (eff_cap > MAX_SLOTS_DEF) begin
                eff_cap = MAX_SLOTS_DEF;
            end
            idle_on = (p % 3 != 2) && (p != PHASES - 1);
            if (!keep_plan[p]) begin
                send_request(REQ_CLEAR, $urandom, $urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == 20) begin
                    hold_req = 1'b1;
                end
                random_request(eff_cap);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests over %0d capacity settings, %0d items checked,",
                 sent, PHASES + 1, checked);
        $display("including capacities 0, 1, 256 and 511 and %0d long output hold-off.",
                 holds_done);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
